/* rtl/stbs_pkg.sv */
// ---------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search block.
// ---------------------------------------------------------------------------
package stbs_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int IDX_W           = 10;
   localparam int VAL_W           = 32;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_ANY   = 2'd1,
      OP_FIRST = 2'd2,
      OP_LAST  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type                    operation;
      logic [IDX_W-1:0]          index;
      logic signed [VAL_W-1:0]   value;
      logic [IDX_W-1:0]          range_start;
      logic [IDX_W-1:0]          range_end;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] position;
   } rsp_type;

endpackage

/* rtl/sorted_table_binary_search.sv */
// ---------------------------------------------------------------------------
// sorted_table_binary_search
// Table of signed words written by index, searched by binary search in
// any, first-occurrence or last-occurrence mode over an inclusive range.
// ---------------------------------------------------------------------------
//  channel | dir | ports                          | moves
//  req     | in  | req_valid, req_stall, req_data | write or search request
//  rsp     | out | rsp_valid, rsp_stall, rsp_data | one result per search
//
//  A write gives no result.
//  A search is accepted, probes the table once per step (one table read per
//  probe) and then loads the result into the output register.
//  req_stall stays high from the accepted search until its result is loaded
//  into the output register; a stalled result holds there.
//  Synchronous active-high reset clears control; table contents are not reset.
// ---------------------------------------------------------------------------
module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stbs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stbs_pkg::rsp_type rsp_data
);
   import stbs_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int WW = ((AW > IDX_W) ? AW : IDX_W) + 2;

   localparam logic signed [WW-1:0] ZERO_W  = WW'(0);
   localparam logic signed [WW-1:0] ONE_W   = WW'(1);
   localparam logic signed [WW-1:0] DEPTH_W = WW'(TABLE_DEPTH);
   localparam logic signed [WW-1:0] LAST_W  = WW'(TABLE_DEPTH - 1);

   logic signed [VAL_W-1:0] mem [TABLE_DEPTH];

   state_type               state_ff, state_in;
   logic signed [WW-1:0]    lo_ff, lo_in;
   logic signed [WW-1:0]    hi_ff, hi_in;
   logic signed [WW-1:0]    mid_ff;
   logic signed [VAL_W-1:0] key_ff, key_in;
   op_type                  mode_ff, mode_in;
   logic                    found_ff, found_in;
   logic [IDX_W-1:0]        pos_ff, pos_in;
   logic signed [VAL_W-1:0] rdata_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff;

   logic signed [WW-1:0] idx_ext, start_ext, end_ext, hi_sat;
   logic signed [WW-1:0] nlo, nhi, lo_sel, hi_sel, sum, mid_calc;
   logic                 search_go, write_go, start_empty;
   logic                 cmp_eq, cmp_gt, hit_done, probe_empty;
   logic                 rsp_load;
   op_type               mode_sel;

   // ---------------- datapath ----------------
   always_comb begin
      idx_ext   = $signed({{(WW-IDX_W){1'b0}}, req_data.index});
      start_ext = $signed({{(WW-IDX_W){1'b0}}, req_data.range_start});
      end_ext   = $signed({{(WW-IDX_W){1'b0}}, req_data.range_end});
      hi_sat    = (end_ext > LAST_W) ? LAST_W : end_ext;
      start_empty = start_ext > hi_sat;

      write_go  = (state_ff == ST_IDLE) && req_valid && (req_data.operation == OP_WRITE);
      search_go = (state_ff == ST_IDLE) && req_valid && (req_data.operation != OP_WRITE);

      cmp_eq = (rdata_ff == key_ff);
      cmp_gt = (rdata_ff > key_ff);

      nlo = lo_ff;
      nhi = hi_ff;
      if (cmp_eq) begin
         if (mode_ff == OP_FIRST) begin
            nhi = mid_ff;
         end else begin
            nlo = mid_ff;
         end
      end else if (cmp_gt) begin
         nhi = mid_ff - ONE_W;
      end else begin
         nlo = mid_ff + ONE_W;
      end
      hit_done    = cmp_eq && ((mode_ff == OP_ANY) || (lo_ff == hi_ff));
      probe_empty = nlo > nhi;

      // probe address: first probe from the request, later ones from the update
      if (state_ff == ST_IDLE) begin
         lo_sel   = start_ext;
         hi_sel   = hi_sat;
         mode_sel = req_data.operation;
      end else begin
         lo_sel   = nlo;
         hi_sel   = nhi;
         mode_sel = mode_ff;
      end
      sum      = lo_sel + hi_sel + ((mode_sel == OP_LAST) ? ONE_W : ZERO_W);
      mid_calc = sum >>> 1;

      rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (search_go) begin
               state_in = start_empty ? ST_DONE : ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (hit_done || probe_empty) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- outputs and register next values ----------------
   always_comb begin
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      key_in       = key_ff;
      mode_in      = mode_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      req_stall    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (search_go) begin
               lo_in    = start_ext;
               hi_in    = hi_sat;
               key_in   = req_data.value;
               mode_in  = req_data.operation;
               found_in = 1'b0;
               pos_in   = '0;
            end
         end
         ST_PROBE: begin
            lo_in = nlo;
            hi_in = nhi;
            if (hit_done) begin
               found_in = 1'b1;
               pos_in   = mid_ff[IDX_W-1:0];
            end else begin
               found_in = 1'b0;
               pos_in   = '0;
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      key_ff   <= key_in;
      mode_ff  <= mode_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
      mid_ff   <= mid_calc;
      if (rsp_load) begin
         rsp_data_ff.found    <= found_ff;
         rsp_data_ff.position <= pos_ff;
      end
   end

   // table: at most one write and one read per cycle
   always_ff @(posedge clock) begin
      if (write_go && (idx_ext < DEPTH_W)) begin
         mem[idx_ext[AW-1:0]] <= req_data.value;
      end
      rdata_ff <= mem[mid_calc[AW-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/stbs_checker.sv */
// ---------------------------------------------------------------------------
// stbs_checker
// Port-level checks for the sorted table binary search block.
// ---------------------------------------------------------------------------
module stbs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input stbs_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input stbs_pkg::rsp_type rsp_data
);
   import stbs_pkg::*;

   // a result waiting on the consumer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a miss reports position zero
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.position == '0)
      else $error("miss with non-zero position");

   // a search keeps the request side busy for at least the next cycle
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.operation != OP_WRITE) |=> req_stall)
      else $error("request taken during a search");

   // a table write leaves the request side free in the next cycle
   a_write_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.operation == OP_WRITE) |=> !req_stall)
      else $error("write held the request side");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (.*);
